// ===== rtl/gimli_sponge_hash_unit_defines.svh =====
// Assertion macros used by the sponge hash controller.
`ifndef GIMLI_SPONGE_HASH_UNIT_DEFINES_SVH
`define GIMLI_SPONGE_HASH_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define GSH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define GSH_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition");

`else

`define GSH_ASSERT(label, clk, rst, prop)

`define GSH_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== rtl/gsh_pkg.sv =====
// Shared types and constants for the sponge hash unit.
package gsh_pkg;

   localparam int DEFAULT_ROUNDS = 24;
   localparam int ROUND_W = 5;
   localparam int RATE_BYTES = 16;
   localparam int POS_W = 4;
   localparam int LEN_W = 7;
   localparam logic [LEN_W-1:0] DIGEST_LEN_RESET = 7'd32;
   localparam logic [LEN_W-1:0] MAX_DIGEST = 7'd64;
   localparam logic [31:0] ROUND_CONST = 32'h9e377900;
   localparam logic [7:0] PAD_FIRST = 8'h1F;
   localparam logic [7:0] PAD_LAST = 8'h80;

   typedef logic [11:0][31:0] words_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB_PERM,
      ST_PAD,
      ST_PAD_PERM,
      ST_SQUEEZE,
      ST_SQUEEZE_PERM,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic               absorb;
      logic               pad;
      logic               round;
      logic [ROUND_W-1:0] round_num;
      logic               clear;
      logic               pos_reset;
      logic               pos_inc;
   } cmd_type;

   typedef struct packed {
      logic pos_last;
   } status_type;

endpackage

// ===== rtl/gsh_datapath.sv =====
// Sponge state, rate position and one Gimli round per cycle.
module gsh_datapath
   import gsh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic [7:0] msg_byte,
   output status_type status,
   output logic [7:0] digest_byte
);

   words_type          sponge_ff, sponge_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [127:0]       rate;
   logic [127:0]       xor_mask;
   logic [6:0]         bit_off;

   function automatic words_type gimli_round(words_type s, logic [ROUND_W-1:0] r);
      words_type   t;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] d;
      logic [31:0] x;
      begin
         t = s;
         for (int c = 0; c < 4; c++) begin
            a = {s[c][7:0], s[c][31:8]};
            b = {s[4+c][22:0], s[4+c][31:23]};
            d = s[8+c];
            t[8+c] = a ^ (d << 1) ^ ((b & d) << 2);
            t[4+c] = b ^ a ^ ((a | d) << 1);
            t[c]   = d ^ b ^ ((a & b) << 3);
         end
         case (r[1:0])
            2'd0: begin
               x = t[0]; t[0] = t[1]; t[1] = x;
               x = t[2]; t[2] = t[3]; t[3] = x;
               t[0] = t[0] ^ (ROUND_CONST | 32'(r));
            end
            2'd2: begin
               x = t[0]; t[0] = t[2]; t[2] = x;
               x = t[1]; t[1] = t[3]; t[3] = x;
            end
            default: begin
               x = t[0];
               t[0] = x;
            end
         endcase
         return t;
      end
   endfunction

   assign rate    = sponge_ff[3:0];
   assign bit_off = {pos_ff, 3'b000};

   always_comb begin
      xor_mask = '0;
      if (cmd.absorb) begin
         xor_mask = 128'(msg_byte) << bit_off;
      end else if (cmd.pad) begin
         xor_mask = (128'(PAD_FIRST) << bit_off) ^ {PAD_LAST, 120'd0};
      end
   end

   always_comb begin
      sponge_in = sponge_ff;
      if (cmd.clear) begin
         sponge_in = '0;
      end else if (cmd.round) begin
         sponge_in = gimli_round(sponge_ff, cmd.round_num);
      end else begin
         sponge_in[3:0] = rate ^ xor_mask;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.clear || cmd.pos_reset) begin
         pos_in = '0;
      end else if (cmd.absorb || cmd.pos_inc) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sponge_ff <= '0;
         pos_ff    <= '0;
      end else begin
         sponge_ff <= sponge_in;
         pos_ff    <= pos_in;
      end
   end

   assign status.pos_last = (pos_ff == POS_W'(RATE_BYTES - 1));
   assign digest_byte     = rate[bit_off +: 8];

endmodule

// ===== rtl/gsh_ctrl.sv =====
// Controller: handshakes, round counter, digest length and squeeze count.
`include "gimli_sponge_hash_unit_defines.svh"
module gsh_ctrl
   import gsh_pkg::*;
#(
   parameter int ROUNDS = DEFAULT_ROUNDS
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_has_byte,
   input  logic             req_end_of_message,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_digest_last,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data,
   input  status_type       status,
   output cmd_type          cmd
);

   state_type          state_ff, state_in;
   logic [ROUND_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   k_ff, k_in;
   logic               eom_ff, eom_in;
   logic [LEN_W-1:0]   len_eff;
   logic               req_take;
   logic               rsp_take;
   logic               round_done;

   assign len_eff    = (len_ff > MAX_DIGEST) ? MAX_DIGEST : len_ff;
   assign req_take   = req_valid && !req_stall;
   assign rsp_take   = rsp_valid && !rsp_stall;
   assign round_done = (cnt_ff == ROUND_W'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_has_byte && status.pos_last) begin
                  state_in = ST_ABSORB_PERM;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ABSORB_PERM: begin
            if (round_done) begin
               state_in = eom_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: state_in = ST_PAD_PERM;
         ST_PAD_PERM: begin
            if (round_done) begin
               state_in = (len_eff == '0) ? ST_CLEAR : ST_SQUEEZE;
            end
         end
         ST_SQUEEZE: begin
            if (rsp_take) begin
               if (rsp_digest_last) begin
                  state_in = ST_IDLE;
               end else if (status.pos_last) begin
                  state_in = ST_SQUEEZE_PERM;
               end
            end
         end
         ST_SQUEEZE_PERM: begin
            if (round_done) begin
               state_in = ST_SQUEEZE;
            end
         end
         ST_CLEAR: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall       = (state_ff != ST_IDLE);
      rsp_valid       = (state_ff == ST_SQUEEZE);
      rsp_digest_last = ((k_ff + LEN_W'(1)) == len_eff);
      cmd             = '0;
      cmd.round_num   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: cmd.absorb = req_take && req_has_byte;
         ST_ABSORB_PERM, ST_SQUEEZE_PERM: cmd.round = 1'b1;
         ST_PAD: cmd.pad = 1'b1;
         ST_PAD_PERM: begin
            cmd.round     = 1'b1;
            cmd.pos_reset = round_done;
         end
         ST_SQUEEZE: begin
            cmd.clear   = rsp_take && rsp_digest_last;
            cmd.pos_inc = rsp_take;
         end
         ST_CLEAR: cmd.clear = 1'b1;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      k_in   = k_ff;
      eom_in = eom_ff;
      len_in = csr_wr_en ? csr_wr_data : len_ff;
      if (req_take) begin
         eom_in = req_end_of_message;
         cnt_in = ROUND_W'(ROUNDS);
      end else if (state_ff == ST_PAD || state_ff == ST_SQUEEZE) begin
         cnt_in = ROUND_W'(ROUNDS);
      end else if (cmd.round) begin
         cnt_in = cnt_ff - ROUND_W'(1);
      end
      if (state_ff == ST_PAD) begin
         k_in = '0;
      end else if (rsp_take) begin
         k_in = k_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         k_ff     <= '0;
         eom_ff   <= 1'b0;
         len_ff   <= DIGEST_LEN_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
         eom_ff   <= eom_in;
         len_ff   <= len_in;
      end
   end

   `GSH_ASSERT_NEVER(a_valid_while_ready, clock, reset, rsp_valid && !req_stall)
   `GSH_ASSERT_NEVER(a_round_cnt_zero, clock, reset, cmd.round && (cnt_ff == '0))
   `GSH_ASSERT(a_last_to_idle, clock, reset, (rsp_take && rsp_digest_last) |=> (state_ff == ST_IDLE))
   `GSH_ASSERT_NEVER(a_squeeze_overrun, clock, reset, rsp_valid && (k_ff >= len_eff))

endmodule

// ===== rtl/gimli_sponge_hash_unit.sv =====
// Sponge hash on the Gimli permutation: one message byte is absorbed per transaction.
// A full 16-byte rate block is permuted (one round per cycle) before the next byte is taken.
// End of message: a pad step and the permutation, then one digest byte per cycle while rsp_stall is low,
// with a permutation between 16-byte output blocks; a zero digest length goes through the clear state.
// Synchronous reset clears the sponge state and position and sets digest_len to 32.
module gimli_sponge_hash_unit
   import gsh_pkg::*;
#(
   parameter int ROUNDS = DEFAULT_ROUNDS
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_msg_byte,
   input  logic             req_has_byte,
   input  logic             req_end_of_message,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_digest_byte,
   output logic             rsp_digest_last,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   gsh_ctrl #(
      .ROUNDS(ROUNDS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_has_byte      (req_has_byte),
      .req_end_of_message(req_end_of_message),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_digest_last   (rsp_digest_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .status            (status),
      .cmd               (cmd)
   );

   gsh_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .msg_byte   (req_msg_byte),
      .status     (status),
      .digest_byte(rsp_digest_byte)
   );

endmodule
